// File: rtl/assert_macros.svh
// Assertion macros included by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// File: rtl/idts_pkg.sv
`default_nettype none

package idts_pkg;

  localparam int unsigned DefMaxAttempts = 50;
  localparam int unsigned AttW = 6;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_START  = 5'b00010,
    PH_ADDR   = 5'b00100,
    PH_FIRST  = 5'b01000,
    PH_SECOND = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_STATUS = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_XFER  = 2'd1,
    OP_RACK  = 2'd2,
    OP_STOP  = 2'd3
  } bus_op_e;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_START_STAGE = 3'd1,
    RC_BAD_START   = 3'd2,
    RC_ADDR_STAGE  = 3'd3,
    RC_BAD_ADDR    = 3'd4,
    RC_FIRST_BYTE  = 3'd5,
    RC_SECOND_BYTE = 3'd6
  } result_code_e;

  typedef enum logic [2:0] {
    REG_MAX_MV  = 3'd0,
    REG_NIBBLE  = 3'd1,
    REG_ADDR_0  = 3'd2,
    REG_ADDR_1  = 3'd3,
    REG_ADDR_2  = 3'd4,
    REG_ADDR_3  = 3'd5
  } cfg_reg_e;

  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRestart    = 8'h10;
  localparam logic [7:0] StSlaWAck    = 8'h18;
  localparam logic [7:0] StSlaWNack   = 8'h20;
  localparam logic [7:0] StDataTxAck  = 8'h28;
  localparam logic [7:0] StArbLost    = 8'h38;
  localparam logic [7:0] StSlaRAck    = 8'h40;
  localparam logic [7:0] StSlaRNack   = 8'h48;
  localparam logic [7:0] StDataRxAck  = 8'h50;
  localparam logic [7:0] StDataRxNack = 8'h58;
  localparam logic [7:0] StMask       = 8'hF8;

  typedef struct packed {
    logic        kind;
    logic [1:0]  bus_op;
    logic [7:0]  tx_byte;
    logic [2:0]  result_code;
    logic [10:0] read_millivolts;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/i2c_dac_transaction_sequencer.sv
// Two-byte bus transaction sequencer for four converter channels.
// Input stream (s_axis): tuser carries the mode (write request, read request or
// bus status report); tdata carries channel, millivolts, bus status and received byte.
// Output stream (m_axis): tuser carries the kind (bus command or finished), tdata
// carries the command or completion fields, and tlast marks the last result of an input.
// Configuration writes go through cfg_valid_i/cfg_index_i/cfg_data_i and are always
// taken; write them only while no transaction is in flight.
// Each input transfer is decoded in the cycle it is accepted, updating the sequencer
// state and pushing zero, one or two results into a four-entry output queue.
// Each result is registered in the output queue before it appears on m_axis.
// One input transfer per cycle is sustained while the receiver takes one result per
// cycle; an input that gives two results (stop plus finish) puts both into the queue.
// s_axis_tready_o is high while the queue has room for two results, so a stalled
// receiver holds its results in order and back-pressures the input once more than two are queued.
// Reset empties the queue, returns the sequencer to idle and loads the register defaults
// (clamp 2047, config nibble 0, channel addresses 12 to 15).

`default_nettype none

module i2c_dac_transaction_sequencer
  import idts_pkg::*;
#(
  parameter int unsigned MAX_ATTEMPTS = DefMaxAttempts
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // channel[1:0], millivolts[17:2], bus_status[25:18], rx_byte[33:26], zero fill
  input  wire logic [39:0] s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // bus_op[1:0], tx_byte[9:2], result_code[12:10], read_millivolts[23:13]
  output logic [23:0]      m_axis_tdata_o,
  // kind[0]
  output logic [0:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam logic [AttW-1:0] MaxAtt = AttW'(MAX_ATTEMPTS);
  localparam int unsigned PtrW = $clog2(FifoDepth);

  logic [10:0]     max_mv_q;
  logic [3:0]      nibble_q;
  logic [6:0]      addr_q [4];

  phase_e          phase_q, phase_d;
  logic [AttW-1:0] attempts_q, attempts_d;
  logic            is_read_q, is_read_d;
  logic [6:0]      target_q, target_d;
  logic [7:0]      frame_high_q, frame_high_d;
  logic [7:0]      frame_low_q, frame_low_d;
  logic [3:0]      rhn_q, rhn_d;
  logic [2:0]      stage_q, stage_d;

  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q, cnt_d;

  logic            in_acc, out_pop;
  logic [1:0]      in_mode;
  logic [1:0]      in_channel;
  logic [15:0]     in_mv;
  logic [7:0]      in_st;
  logic [7:0]      in_rx;

  logic            start_req, stop_req, cmd_req;
  logic [2:0]      stop_code;
  logic [10:0]     stop_mv;
  logic [1:0]      cmd_op;
  logic [7:0]      cmd_tx;
  logic [10:0]     clamp_mv;
  logic [11:0]     data12;
  result_t         r0, r1;
  logic [1:0]      nres;

  assign in_mode    = s_axis_tuser_i;
  assign in_channel = s_axis_tdata_i[1:0];
  assign in_mv      = s_axis_tdata_i[17:2];
  assign in_st      = s_axis_tdata_i[25:18] & StMask;
  assign in_rx      = s_axis_tdata_i[33:26];

  assign s_axis_tready_o = (cnt_q <= (PtrW+1)'(FifoDepth - 2));
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tdata_o = {fifo_q[rd_ptr_q].read_millivolts, fifo_q[rd_ptr_q].result_code,
                           fifo_q[rd_ptr_q].tx_byte, fifo_q[rd_ptr_q].bus_op};
  assign m_axis_tuser_o = fifo_q[rd_ptr_q].kind;
  assign m_axis_tlast_o = fifo_q[rd_ptr_q].last;

  assign clamp_mv = (in_mv > {5'd0, max_mv_q}) ? max_mv_q : in_mv[10:0];
  assign data12   = {clamp_mv, 1'b0};

  always_comb begin
    phase_d      = phase_q;
    attempts_d   = attempts_q;
    is_read_d    = is_read_q;
    target_d     = target_q;
    frame_high_d = frame_high_q;
    frame_low_d  = frame_low_q;
    rhn_d        = rhn_q;
    stage_d      = stage_q;
    start_req    = 1'b0;
    stop_req     = 1'b0;
    cmd_req      = 1'b0;
    stop_code    = RC_OK;
    stop_mv      = '0;
    cmd_op       = OP_XFER;
    cmd_tx       = '0;
    r0           = '0;
    r1           = '0;
    nres         = 2'd0;

    if (in_acc) begin
      case (in_mode)
        MODE_WRITE, MODE_READ: begin
          if (phase_q == PH_IDLE) begin
            is_read_d  = in_mode[0];
            target_d   = addr_q[in_channel];
            if (in_mode == MODE_WRITE) begin
              frame_high_d = {nibble_q, data12[11:8]};
              frame_low_d  = data12[7:0];
            end
            attempts_d = '0;
            stage_d    = RC_START_STAGE;
            start_req  = 1'b1;
          end
        end
        MODE_STATUS: begin
          case (phase_q)
            PH_IDLE: ;
            PH_START: begin
              if (in_st == StArbLost) begin
                start_req = 1'b1;
              end else if (in_st != StStart && in_st != StRestart) begin
                stage_d   = RC_BAD_START;
                stop_req  = 1'b1;
                stop_code = RC_BAD_START;
              end else begin
                stage_d = RC_ADDR_STAGE;
                phase_d = PH_ADDR;
                cmd_req = 1'b1;
                cmd_op  = OP_XFER;
                cmd_tx  = {target_q, is_read_q};
              end
            end
            PH_ADDR: begin
              if (in_st == StArbLost ||
                  in_st == (is_read_q ? StSlaRNack : StSlaWNack)) begin
                start_req = 1'b1;
              end else if (in_st != (is_read_q ? StSlaRAck : StSlaWAck)) begin
                stage_d   = RC_BAD_ADDR;
                stop_req  = 1'b1;
                stop_code = RC_BAD_ADDR;
              end else begin
                stage_d = RC_FIRST_BYTE;
                phase_d = PH_FIRST;
                cmd_req = 1'b1;
                cmd_op  = is_read_q ? OP_RACK : OP_XFER;
                cmd_tx  = is_read_q ? 8'd0 : frame_high_q;
              end
            end
            PH_FIRST: begin
              if (in_st != (is_read_q ? StDataRxAck : StDataTxAck)) begin
                stop_req  = 1'b1;
                stop_code = RC_FIRST_BYTE;
              end else begin
                stage_d = RC_SECOND_BYTE;
                phase_d = PH_SECOND;
                cmd_req = 1'b1;
                cmd_op  = OP_XFER;
                if (is_read_q) begin
                  rhn_d = in_rx[3:0];
                end else begin
                  cmd_tx = frame_low_q;
                end
              end
            end
            PH_SECOND: begin
              stop_req = 1'b1;
              if (in_st != (is_read_q ? StDataRxNack : StDataTxAck)) begin
                stop_code = RC_SECOND_BYTE;
              end else if (is_read_q) begin
                stop_mv = {rhn_q, in_rx[7:1]};
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end

    if (start_req) begin
      nres    = 2'd1;
      r0.last = 1'b1;
      if (attempts_d >= MaxAtt) begin
        phase_d        = PH_IDLE;
        r0.kind        = 1'b1;
        r0.result_code = stage_d;
      end else begin
        attempts_d = attempts_d + 1'b1;
        phase_d    = PH_START;
        r0.bus_op  = OP_START;
      end
    end else if (stop_req) begin
      nres               = 2'd2;
      phase_d            = PH_IDLE;
      r0.bus_op          = OP_STOP;
      r1.kind            = 1'b1;
      r1.result_code     = stop_code;
      r1.read_millivolts = stop_mv;
      r1.last            = 1'b1;
    end else if (cmd_req) begin
      nres       = 2'd1;
      r0.bus_op  = cmd_op;
      r0.tx_byte = cmd_tx;
      r0.last    = 1'b1;
    end
  end

  assign cnt_d = cnt_q + (PtrW+1)'(nres) - (PtrW+1)'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mv_q     <= 11'd2047;
      nibble_q     <= '0;
      addr_q[0]    <= 7'd12;
      addr_q[1]    <= 7'd13;
      addr_q[2]    <= 7'd14;
      addr_q[3]    <= 7'd15;
      phase_q      <= PH_IDLE;
      attempts_q   <= '0;
      is_read_q    <= 1'b0;
      target_q     <= '0;
      frame_high_q <= '0;
      frame_low_q  <= '0;
      rhn_q        <= '0;
      stage_q      <= RC_START_STAGE;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MAX_MV: max_mv_q  <= cfg_data_i;
          REG_NIBBLE: nibble_q  <= cfg_data_i[3:0];
          REG_ADDR_0: addr_q[0] <= cfg_data_i[6:0];
          REG_ADDR_1: addr_q[1] <= cfg_data_i[6:0];
          REG_ADDR_2: addr_q[2] <= cfg_data_i[6:0];
          REG_ADDR_3: addr_q[3] <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      attempts_q   <= attempts_d;
      is_read_q    <= is_read_d;
      target_q     <= target_d;
      frame_high_q <= frame_high_d;
      frame_low_q  <= frame_low_d;
      rhn_q        <= rhn_d;
      stage_q      <= stage_d;
      wr_ptr_q     <= wr_ptr_q + PtrW'(nres);
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (nres == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= r1;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_bound, clk_i, rst_ni, cnt_q > (PtrW+1)'(FifoDepth))
  `ASSERT_IMPLIES(a_room_for_pair, clk_i, rst_ni, in_acc, cnt_q <= (PtrW+1)'(FifoDepth - 2))
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i && !in_acc,
               $stable(cnt_q) && $stable(rd_ptr_q))
  `ASSERT_NEVER(a_attempt_limit, clk_i, rst_ni, attempts_q > MaxAtt)

endmodule

`default_nettype wire
